[rtl/core/rwl_pkg.sv]
// ----------------------------------------------------------------------------
// rwl_pkg
// Shared types and constants of the FIFO-fair reader-writer lock arbiter:
// request and result payloads, opcodes, event kinds and sizing.
// ----------------------------------------------------------------------------
package rwl_pkg;

  // Sizing
  localparam int QUEUE_DEPTH  = 16;
  localparam int READER_LIMIT = 255;
  localparam int MAX_RESULTS  = 16;
  localparam int QIDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QPOS_W       = QIDX_W + 1;
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int NCNT_W       = $clog2(MAX_RESULTS + 1);
  localparam logic [7:0] READER_CAP = 8'((READER_LIMIT < 255) ? READER_LIMIT : 255);

  // Request opcodes
  localparam logic [1:0] OP_ACQ_READ  = 2'd0;
  localparam logic [1:0] OP_ACQ_WRITE = 2'd1;
  localparam logic [1:0] OP_RELEASE   = 2'd2;

  // Result event kinds
  localparam logic [2:0] EV_GRANTED    = 3'd0;
  localparam logic [2:0] EV_QUEUED     = 3'd1;
  localparam logic [2:0] EV_RELEASED   = 3'd2;
  localparam logic [2:0] EV_ADMITTED   = 3'd3;
  localparam logic [2:0] EV_REL_ERROR  = 3'd4;
  localparam logic [2:0] EV_FULL_ERROR = 3'd5;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] requester_id;
  } req_t;

  typedef struct packed {
    logic [2:0] event_kind;
    logic [7:0] grantee_id;
    logic       grantee_is_writer;
    logic [7:0] readers_now;
    logic       writer_now;
    logic [4:0] waiting_now;
    logic       last;
  } rsp_t;

  // Classified request handed from front to engine
  typedef enum logic [1:0] {
    CMD_READ,
    CMD_WRITE,
    CMD_RELEASE
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e  kind;
    logic [7:0] id;
  } cmd_t;

  // One waiter in the wait queue
  typedef struct packed {
    logic       wants_write;
    logic [7:0] id;
  } wait_entry_t;

  typedef enum logic [1:0] {
    ENG_IDLE,
    ENG_READ,
    ENG_EVAL,
    ENG_FLUSH
  } eng_state_e;

endpackage

[rtl/core/fifo_reader_writer_lock.sv]
// Result path: a request is registered in the front queue, and its result is
//   registered in the result queue before it shows on the result ports.
// Throughput: one acquire or simple release per cycle while no drain runs and the
//   result queue has room; a release that wakes k waiters runs a read and an
//   evaluate per admission, then a flush or a failed evaluate of the next waiter.
// Reset: rst_ni clears lock state, queue pointers and both buffers; wait-queue
//   contents are left as they are, no clearing pass.
// ----------------------------------------------------------------------------
// fifo_reader_writer_lock
// FIFO-fair reader-writer lock arbiter: front end classifies requests, the
// engine grants, queues and drains waiters, a result queue feeds the consumer.
// ----------------------------------------------------------------------------
module fifo_reader_writer_lock (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push,
  output logic            full,
  input  rwl_pkg::req_t   req_i,
  output logic            empty,
  input  logic            pop,
  output rwl_pkg::rsp_t   rsp_o
);

  logic          cmd_valid;
  rwl_pkg::cmd_t cmd;
  logic          cmd_take;
  logic          rsp_full;
  logic          rsp_push;
  rwl_pkg::rsp_t rsp;

  // Accept and classify requests
  rwl_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .req_i       (req_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_take_i  (cmd_take)
  );

  // Carry out lock operations
  rwl_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_take_o  (cmd_take),
    .rsp_full_i  (rsp_full),
    .rsp_push_o  (rsp_push),
    .rsp_o       (rsp)
  );

  // Buffer results
  rwl_rsp_queue u_rsp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rsp_push),
    .data_i  (rsp),
    .full_o  (rsp_full),
    .empty_o (empty),
    .pop_i   (pop),
    .data_o  (rsp_o)
  );

endmodule

[rtl/core/rwl_front.sv]
// ----------------------------------------------------------------------------
// rwl_front
// Request front end: accepts requests, classifies the opcode, drops unused
// codes and buffers classified requests in a two-entry queue for the engine.
// ----------------------------------------------------------------------------
module rwl_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  output logic            full_o,
  input  rwl_pkg::req_t   req_i,
  output logic            cmd_valid_o,
  output rwl_pkg::cmd_t   cmd_o,
  input  logic            cmd_take_i
);

  rwl_pkg::cmd_t ent_q [2];
  logic          wr_ptr_q, wr_ptr_d;
  logic          rd_ptr_q, rd_ptr_d;
  logic [1:0]    cnt_q, cnt_d;
  logic          keep;
  rwl_pkg::cmd_t cmd_new;
  logic          do_push, do_pop;

  // Classify the opcode
  always_comb begin
    keep         = 1'b1;
    cmd_new.id   = req_i.requester_id;
    cmd_new.kind = rwl_pkg::CMD_READ;
    case (req_i.opcode)
      rwl_pkg::OP_ACQ_READ:  cmd_new.kind = rwl_pkg::CMD_READ;
      rwl_pkg::OP_ACQ_WRITE: cmd_new.kind = rwl_pkg::CMD_WRITE;
      rwl_pkg::OP_RELEASE:   cmd_new.kind = rwl_pkg::CMD_RELEASE;
      default:               keep = 1'b0;
    endcase
  end

  assign full_o      = (cnt_q == 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = ent_q[rd_ptr_q];
  assign do_push     = push_i && !full_o && keep;
  assign do_pop      = cmd_take_i && cmd_valid_o;

  // Advance pointers and count
  always_comb begin
    wr_ptr_d = do_push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Hold request payload
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      ent_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

[rtl/core/rwl_engine.sv]
// ----------------------------------------------------------------------------
// rwl_engine
// Lock engine: holds reader count, writer flag and the wait queue, grants or
// queues acquires, and on a release that frees the lock drains waiters from
// the head of the queue, one admission per read/evaluate pass.
// ----------------------------------------------------------------------------
module rwl_engine (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cmd_valid_i,
  input  rwl_pkg::cmd_t   cmd_i,
  output logic            cmd_take_o,
  input  logic            rsp_full_i,
  output logic            rsp_push_o,
  output rwl_pkg::rsp_t   rsp_o
);

  rwl_pkg::eng_state_e          state_q, state_d;
  logic [7:0]                   reader_q, reader_d;
  logic                         writer_q, writer_d;
  logic [rwl_pkg::QIDX_W-1:0]   head_q, head_d;
  logic [rwl_pkg::QCNT_W-1:0]   fill_q, fill_d;
  logic [rwl_pkg::NCNT_W-1:0]   adm_cnt_q, adm_cnt_d;
  logic                         pend_valid_q, pend_valid_d;
  rwl_pkg::rsp_t                pend_q, pend_d;
  rwl_pkg::wait_entry_t         entry_q;
  rwl_pkg::wait_entry_t         mem [rwl_pkg::QUEUE_DEPTH];

  logic                         mem_we;
  rwl_pkg::wait_entry_t         mem_wdata;
  logic [rwl_pkg::QPOS_W-1:0]   tail_sum;
  logic [rwl_pkg::QIDX_W-1:0]   tail;
  logic [rwl_pkg::QIDX_W-1:0]   head_next;
  logic                         take;
  logic                         is_wr;
  logic                         acq_now;
  logic                         rel_ok;
  logic [7:0]                   reader_rel;
  logic                         writer_rel;
  logic                         freed;
  logic                         admit;
  logic [rwl_pkg::QCNT_W-1:0]   fill_dec;
  logic [rwl_pkg::NCNT_W-1:0]   adm_inc;
  logic                         more;

  function automatic rwl_pkg::rsp_t mk_rsp(
    input logic [2:0]                 kind,
    input logic [7:0]                 id,
    input logic                       wr,
    input logic [7:0]                 readers,
    input logic                       writer,
    input logic [rwl_pkg::QCNT_W-1:0] fill,
    input logic                       last
  );
    rwl_pkg::rsp_t r;
    r.event_kind        = kind;
    r.grantee_id        = id;
    r.grantee_is_writer = wr;
    r.readers_now       = readers;
    r.writer_now        = writer;
    r.waiting_now       = 5'(fill);
    r.last              = last;
    return r;
  endfunction

  // Decode lock conditions
  always_comb begin
    take       = (state_q == rwl_pkg::ENG_IDLE) && cmd_valid_i && !rsp_full_i;
    is_wr      = (cmd_i.kind == rwl_pkg::CMD_WRITE);
    acq_now    = (fill_q == '0) && !writer_q && (!is_wr || reader_q == 8'd0);
    rel_ok     = (reader_q != 8'd0) || writer_q;
    reader_rel = (reader_q != 8'd0) ? reader_q - 8'd1 : reader_q;
    writer_rel = writer_q && (reader_q != 8'd0);
    freed      = (reader_rel == 8'd0) && !writer_rel;
    admit      = entry_q.wants_write ? ((reader_q == 8'd0) && !writer_q)
                                     : (!writer_q && (reader_q < rwl_pkg::READER_CAP));
    fill_dec   = fill_q - rwl_pkg::QCNT_W'(1);
    adm_inc    = adm_cnt_q + rwl_pkg::NCNT_W'(1);
    more       = (fill_dec != '0) && (adm_inc < rwl_pkg::NCNT_W'(rwl_pkg::MAX_RESULTS));
    head_next  = (head_q == rwl_pkg::QIDX_W'(rwl_pkg::QUEUE_DEPTH - 1))
                 ? '0 : head_q + rwl_pkg::QIDX_W'(1);
    tail_sum   = rwl_pkg::QPOS_W'(head_q) + rwl_pkg::QPOS_W'(fill_q);
    if (tail_sum >= rwl_pkg::QPOS_W'(rwl_pkg::QUEUE_DEPTH)) begin
      tail_sum = tail_sum - rwl_pkg::QPOS_W'(rwl_pkg::QUEUE_DEPTH);
    end
    tail       = tail_sum[rwl_pkg::QIDX_W-1:0];
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      rwl_pkg::ENG_IDLE: begin
        if (take && cmd_i.kind == rwl_pkg::CMD_RELEASE && rel_ok && freed &&
            fill_q != '0) begin
          state_d = rwl_pkg::ENG_READ;
        end
      end
      rwl_pkg::ENG_READ: begin
        state_d = rwl_pkg::ENG_EVAL;
      end
      rwl_pkg::ENG_EVAL: begin
        if (!rsp_full_i) begin
          if (admit) begin
            state_d = more ? rwl_pkg::ENG_READ : rwl_pkg::ENG_FLUSH;
          end else begin
            state_d = rwl_pkg::ENG_IDLE;
          end
        end
      end
      rwl_pkg::ENG_FLUSH: begin
        if (!rsp_full_i) begin
          state_d = rwl_pkg::ENG_IDLE;
        end
      end
      default: state_d = rwl_pkg::ENG_IDLE;
    endcase
  end

  // Lock datapath and result generation
  always_comb begin
    reader_d     = reader_q;
    writer_d     = writer_q;
    head_d       = head_q;
    fill_d       = fill_q;
    adm_cnt_d    = adm_cnt_q;
    pend_valid_d = pend_valid_q;
    pend_d       = pend_q;
    mem_we       = 1'b0;
    mem_wdata.wants_write = is_wr;
    mem_wdata.id          = cmd_i.id;
    cmd_take_o   = 1'b0;
    rsp_push_o   = 1'b0;
    rsp_o        = '0;
    case (state_q)
      rwl_pkg::ENG_IDLE: begin
        if (take) begin
          cmd_take_o = 1'b1;
          rsp_push_o = 1'b1;
          case (cmd_i.kind)
            rwl_pkg::CMD_READ, rwl_pkg::CMD_WRITE: begin
              if (acq_now) begin
                if (!is_wr && reader_q >= rwl_pkg::READER_CAP) begin
                  rsp_o = mk_rsp(rwl_pkg::EV_FULL_ERROR, 8'd0, 1'b0,
                                 reader_q, writer_q, fill_q, 1'b1);
                end else begin
                  if (is_wr) begin
                    writer_d = 1'b1;
                  end else begin
                    reader_d = reader_q + 8'd1;
                  end
                  rsp_o = mk_rsp(rwl_pkg::EV_GRANTED, cmd_i.id, is_wr,
                                 reader_d, writer_d, fill_q, 1'b1);
                end
              end else if (fill_q == rwl_pkg::QCNT_W'(rwl_pkg::QUEUE_DEPTH)) begin
                rsp_o = mk_rsp(rwl_pkg::EV_FULL_ERROR, 8'd0, 1'b0,
                               reader_q, writer_q, fill_q, 1'b1);
              end else begin
                mem_we = 1'b1;
                fill_d = fill_q + rwl_pkg::QCNT_W'(1);
                rsp_o  = mk_rsp(rwl_pkg::EV_QUEUED, cmd_i.id, is_wr,
                                reader_q, writer_q, fill_d, 1'b1);
              end
            end
            rwl_pkg::CMD_RELEASE: begin
              if (!rel_ok) begin
                rsp_o = mk_rsp(rwl_pkg::EV_REL_ERROR, 8'd0, 1'b0,
                               reader_q, writer_q, fill_q, 1'b1);
              end else begin
                reader_d = reader_rel;
                writer_d = writer_rel;
                if (freed && fill_q != '0) begin
                  // start a drain; results come out of the evaluate passes
                  rsp_push_o   = 1'b0;
                  adm_cnt_d    = '0;
                  pend_valid_d = 1'b0;
                end else begin
                  rsp_o = mk_rsp(rwl_pkg::EV_RELEASED, 8'd0, 1'b0,
                                 reader_rel, writer_rel, fill_q, 1'b1);
                end
              end
            end
            default: rsp_push_o = 1'b0;
          endcase
        end
      end
      rwl_pkg::ENG_READ: begin
        // head entry is fetched in the memory block
      end
      rwl_pkg::ENG_EVAL: begin
        if (!rsp_full_i) begin
          if (admit) begin
            if (entry_q.wants_write) begin
              writer_d = 1'b1;
            end else begin
              reader_d = reader_q + 8'd1;
            end
            head_d       = head_next;
            fill_d       = fill_dec;
            adm_cnt_d    = adm_inc;
            pend_valid_d = 1'b1;
            pend_d       = mk_rsp(rwl_pkg::EV_ADMITTED, entry_q.id, entry_q.wants_write,
                                  reader_d, writer_d, fill_dec, 1'b0);
            // the previous admission is now known not to be the final one
            rsp_push_o   = pend_valid_q;
            rsp_o        = pend_q;
          end else begin
            rsp_push_o   = 1'b1;
            pend_valid_d = 1'b0;
            if (pend_valid_q) begin
              rsp_o      = pend_q;
              rsp_o.last = 1'b1;
            end else begin
              rsp_o = mk_rsp(rwl_pkg::EV_RELEASED, 8'd0, 1'b0,
                             reader_q, writer_q, fill_q, 1'b1);
            end
          end
        end
      end
      rwl_pkg::ENG_FLUSH: begin
        if (!rsp_full_i) begin
          rsp_push_o   = 1'b1;
          rsp_o        = pend_q;
          rsp_o.last   = 1'b1;
          pend_valid_d = 1'b0;
        end
      end
      default: begin
        rsp_push_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= rwl_pkg::ENG_IDLE;
      reader_q     <= 8'd0;
      writer_q     <= 1'b0;
      head_q       <= '0;
      fill_q       <= '0;
      adm_cnt_q    <= '0;
      pend_valid_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      reader_q     <= reader_d;
      writer_q     <= writer_d;
      head_q       <= head_d;
      fill_q       <= fill_d;
      adm_cnt_q    <= adm_cnt_d;
      pend_valid_q <= pend_valid_d;
    end
  end

  // Hold pending admission payload
  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
  end

  // Wait queue memory: write at tail, registered read at head
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[tail] <= mem_wdata;
    end
    if (state_q == rwl_pkg::ENG_READ) begin
      entry_q <= mem[head_q];
    end
  end

endmodule

[rtl/core/rwl_rsp_queue.sv]
// ----------------------------------------------------------------------------
// rwl_rsp_queue
// Two-entry result queue: decouples the lock engine from the result consumer
// and presents the oldest waiting result.
// ----------------------------------------------------------------------------
module rwl_rsp_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  rwl_pkg::rsp_t   data_i,
  output logic            full_o,
  output logic            empty_o,
  input  logic            pop_i,
  output rwl_pkg::rsp_t   data_o
);

  rwl_pkg::rsp_t ent_q [2];
  logic          wr_ptr_q, wr_ptr_d;
  logic          rd_ptr_q, rd_ptr_d;
  logic [1:0]    cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = ent_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Advance pointers and count
  always_comb begin
    wr_ptr_d = do_push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Hold result payload
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      ent_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

[rtl/core/rwl_checker.sv]
// ----------------------------------------------------------------------------
// rwl_checker
// Port-level checks of the reader-writer lock arbiter, bound to the top level.
// ----------------------------------------------------------------------------
module rwl_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          push,
  input logic          full,
  input rwl_pkg::req_t req_i,
  input logic          empty,
  input logic          pop,
  input rwl_pkg::rsp_t rsp_o
);

  // Error and release results carry no grantee
  a_no_grantee: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (rsp_o.event_kind == rwl_pkg::EV_RELEASED ||
                rsp_o.event_kind == rwl_pkg::EV_REL_ERROR ||
                rsp_o.event_kind == rwl_pkg::EV_FULL_ERROR))
    |-> (rsp_o.grantee_id == 8'd0 && !rsp_o.grantee_is_writer))
    else $error("grantee set on a result without one");

  // Readers and a writer never hold the lock together
  a_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> !(rsp_o.writer_now && rsp_o.readers_now != 8'd0))
    else $error("readers and writer both active");

  // Only admissions may be followed by more results of the same request
  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && rsp_o.event_kind != rwl_pkg::EV_ADMITTED) |-> rsp_o.last)
    else $error("single-result event not marked last");

  // A waiting result holds until taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(rsp_o)))
    else $error("waiting result changed");

endmodule

bind fifo_reader_writer_lock rwl_checker u_rwl_checker (.*);
